// ----- sv/wobg_pkg.sv -----
// Package for the write-once block guard.
// Holds the word types, item and status codes, default sizes and the
// command and status structs between controller and datapath. No dependencies.
package wobg_pkg;

  // Default sizes handed to the top level parameters.
  localparam int MAX_BLOCKS_DEF = 65536;
  localparam int MAP_BITS_DEF   = 65440;
  localparam int WORD_BITS_DEF  = 32;

  // Fixed field widths.
  localparam int KIND_W   = 2;
  localparam int BLOCK_W  = 16;
  localparam int STATUS_W = 2;
  localparam int CAP_W    = 17;

  localparam logic [CAP_W-1:0] TOTAL_RESET = 17'd65536;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BOUNDS    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNWRITTEN = 2'd2;
  localparam logic [STATUS_W-1:0] ST_REWRITE   = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [BLOCK_W-1:0] block;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                forward;
    logic [CAP_W-1:0]    capacity;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // take the input word and read its bitmap word
    logic sweep_step;  // zero one bitmap word and advance the sweep pointer
    logic finish;      // produce the result and update the bitmap
  } wobg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_last;  // the sweep pointer is at the last bitmap word
    logic div_busy;    // the capacity is still being computed
  } wobg_sts_t;

endpackage

// ----- sv/write_once_block_guard.sv -----
// Read and write items go through a bitmap word read, then check and set.
// A read or write item is not taken until the one before it is checked; the result register
// lets the next item in while a result waits. A clear item zeroes one bitmap
// word per cycle across the whole bitmap (2048 words by default), then reports.
// After reset a clearing pass over the whole bitmap runs; a size write holds off
// input, in its own cycle and while the quotient and then the capacity are formed.
module write_once_block_guard #(
  parameter int MAX_BLOCKS         = wobg_pkg::MAX_BLOCKS_DEF,
  parameter int MAP_BITS_PER_BLOCK = wobg_pkg::MAP_BITS_DEF,
  parameter int WORD_BITS          = wobg_pkg::WORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  wobg_pkg::in_word_t         in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output wobg_pkg::out_word_t        out_data,
  input  logic                       cfg_we,
  input  logic [wobg_pkg::CAP_W-1:0] cfg_data
);

  wobg_pkg::wobg_cmd_t cmd;
  wobg_pkg::wobg_sts_t sts;

  // Sequencing of sweep, check and handshakes.
  wobg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_data.kind),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_we    (cfg_we),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Bitmap, capacity and result datapath.
  wobg_dpath #(
    .MAX_BLOCKS         (MAX_BLOCKS),
    .MAP_BITS_PER_BLOCK (MAP_BITS_PER_BLOCK),
    .WORD_BITS          (WORD_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// ----- sv/wobg_dpath.sv -----
// Datapath of the write-once block guard: size register, reciprocal-multiply
// capacity, bitmap memory with its sweep pointer, check logic and result
// register. Depends on wobg_pkg.
module wobg_dpath #(
  parameter int MAX_BLOCKS         = wobg_pkg::MAX_BLOCKS_DEF,
  parameter int MAP_BITS_PER_BLOCK = wobg_pkg::MAP_BITS_DEF,
  parameter int WORD_BITS          = wobg_pkg::WORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [wobg_pkg::CAP_W-1:0]  cfg_data,
  input  wobg_pkg::in_word_t          in_data,
  input  wobg_pkg::wobg_cmd_t         cmd,
  output wobg_pkg::wobg_sts_t         sts,
  output wobg_pkg::out_word_t         out_data
);

  // WORD_BITS is a power of two; the block number splits into word and bit.
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CW        = wobg_pkg::CAP_W;

  // Rounded-up reciprocal of the map share: (n * RECIP) >> SH equals the
  // quotient n / MAP_BITS_PER_BLOCK for every CW-bit n.
  localparam int DIV_LOG   = $clog2(MAP_BITS_PER_BLOCK);
  localparam int SH        = CW + DIV_LOG;
  localparam int MW        = CW + 2;
  localparam int PW        = CW + MW;
  localparam logic [63:0] RECIP_WIDE =
    ((64'd1 << SH) + 64'(MAP_BITS_PER_BLOCK) - 64'd1) / 64'(MAP_BITS_PER_BLOCK);
  localparam logic [MW-1:0] RECIP     = RECIP_WIDE[MW-1:0];
  localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

  // Clamp a size value to the largest supported device.
  function automatic logic [CW-1:0] clamp_size(input logic [CW-1:0] val);
    logic [31:0] wide;
    wide = 32'(val);
    if (wide > 32'(MAX_BLOCKS)) begin
      clamp_size = CW'(MAX_BLOCKS);
    end else begin
      clamp_size = val;
    end
  endfunction

  logic [CW-1:0]        size_r;
  logic [CW-1:0]        quo_r;
  logic [CW-1:0]        cap_r;
  logic [1:0]           calc_r;
  logic [AW-1:0]        clr_r;
  logic [wobg_pkg::KIND_W-1:0]  kind_r;
  logic [wobg_pkg::BLOCK_W-1:0] blk_r;
  logic [WORD_BITS-1:0] rd_data_r;
  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  wobg_pkg::out_word_t  out_r;

  logic [PW-1:0]        prod_w;
  logic [PW-1:0]        quo_wide;
  logic [CW:0]          sub_w;
  logic [CW-1:0]        cap_w;
  logic [31:0]          in_widx;
  logic [31:0]          blk_widx;
  logic [AW-1:0]        in_addr;
  logic [AW-1:0]        blk_addr;
  logic [BIT_W-1:0]     bit_idx;
  logic                 in_bounds;
  logic                 bit_set;
  logic                 wr_item;
  logic [WORD_BITS-1:0] wr_word;
  wobg_pkg::out_word_t  res_w;

  // Map share of the clamped size by one multiply with the reciprocal.
  assign prod_w   = PW'(size_r) * PW'(RECIP);
  assign quo_wide = prod_w >> SH;

  // Capacity is the clamped size less the bitmap share and one, floored at zero.
  assign sub_w  = {1'b0, quo_r} + (CW+1)'(1);
  assign cap_w  = (sub_w >= {1'b0, size_r}) ? '0 : (size_r - sub_w[CW-1:0]);

  // Clamped size register; after every write the quotient and then the
  // capacity are registered in turn.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= clamp_size(wobg_pkg::TOTAL_RESET);
      quo_r  <= '0;
      cap_r  <= '0;
      calc_r <= 2'b01;
    end else if (cfg_we) begin
      size_r <= clamp_size(cfg_data);
      calc_r <= 2'b01;
    end else begin
      if (calc_r[0]) begin
        quo_r <= quo_wide[CW-1:0];
      end
      if (calc_r[1]) begin
        cap_r <= cap_w;
      end
      calc_r <= {calc_r[0], 1'b0};
    end
  end

  // Sweep pointer walks the bitmap once per clear.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.sweep_step) begin
      clr_r <= (clr_r == LAST_WORD) ? '0 : (clr_r + AW'(1));
    end
  end

  // Address split of the incoming and the held block number.
  assign in_widx  = 32'(in_data.block >> BIT_W);
  assign blk_widx = 32'(blk_r >> BIT_W);
  assign in_addr  = in_widx[AW-1:0];
  assign blk_addr = blk_widx[AW-1:0];
  assign bit_idx  = blk_r[BIT_W-1:0];

  // Check of the held item against capacity and the fetched bitmap word.
  assign in_bounds = ({1'b0, blk_r} < cap_r) && (blk_widx < 32'(MAP_WORDS));
  assign bit_set   = rd_data_r[bit_idx];
  assign wr_word   = rd_data_r | (WORD_BITS'(1) << bit_idx);

  always_comb begin
    res_w.status   = wobg_pkg::ST_OK;
    res_w.forward  = 1'b0;
    res_w.capacity = cap_r;
    wr_item        = 1'b0;
    case (kind_r)
      wobg_pkg::KIND_READ: begin
        if (!in_bounds) begin
          res_w.status = wobg_pkg::ST_BOUNDS;
        end else if (bit_set) begin
          res_w.forward = 1'b1;
        end else begin
          res_w.status = wobg_pkg::ST_UNWRITTEN;
        end
      end
      wobg_pkg::KIND_WRITE: begin
        if (!in_bounds) begin
          res_w.status = wobg_pkg::ST_BOUNDS;
        end else if (bit_set) begin
          res_w.status = wobg_pkg::ST_REWRITE;
        end else begin
          res_w.forward = 1'b1;
          wr_item       = cmd.finish;
        end
      end
      default: begin
        res_w.status = wobg_pkg::ST_OK;
      end
    endcase
  end

  // Bitmap memory: one write port shared by sweep and set, one read port.
  always_ff @(posedge clk) begin
    if (cmd.sweep_step) begin
      mem[clr_r] <= '0;
    end else if (wr_item) begin
      mem[blk_addr] <= wr_word;
    end
    if (cmd.load) begin
      rd_data_r <= mem[in_addr];
    end
  end

  // Held item and result register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_data.kind;
      blk_r  <= in_data.block;
    end
    if (cmd.finish) begin
      out_r <= res_w;
    end
  end

  assign sts.sweep_last = (clr_r == LAST_WORD);
  assign sts.div_busy   = (calc_r != '0);
  assign out_data       = out_r;

endmodule

// ----- sv/wobg_ctrl.sv -----
// Controller of the write-once block guard: sequences the bitmap sweep,
// the load and check of each item and the result handshake.
// Depends on wobg_pkg.
module wobg_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [wobg_pkg::KIND_W-1:0]  in_kind,
  output logic                         in_stall,
  output logic                         out_valid,
  input  logic                         out_stall,
  input  logic                         cfg_we,
  input  wobg_pkg::wobg_sts_t          sts,
  output wobg_pkg::wobg_cmd_t          cmd
);

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_CHECK
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   item_pend_r;
  logic   item_pend_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   accept;
  logic   out_free;

  // Input is taken only when idle and the capacity is settled.
  assign in_stall = (state_r != S_IDLE) || sts.div_busy || cfg_we;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign cmd.load       = accept;
  assign cmd.sweep_step = (state_r == S_SWEEP);
  assign cmd.finish     = (state_r == S_CHECK) && out_free;

  // Next state; a clear item sweeps first and reports at the end.
  always_comb begin
    state_nxt     = state_r;
    item_pend_nxt = item_pend_r;
    out_valid_nxt = cmd.finish || (out_valid_r && out_stall);
    case (state_r)
      S_SWEEP: begin
        if (sts.sweep_last) begin
          state_nxt     = item_pend_r ? S_CHECK : S_IDLE;
          item_pend_nxt = 1'b0;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_kind == wobg_pkg::KIND_CLEAR) begin
            state_nxt     = S_SWEEP;
            item_pend_nxt = 1'b1;
          end else begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered handshake outputs; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      item_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      item_pend_r <= item_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  // An accepted item is checked next, or first swept when it is a clear.
  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_CHECK) || (state_r == S_SWEEP))
    else $error("accepted item did not enter check or sweep");

  // A running divide always holds off the input.
  a_div_stall: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_busy |-> in_stall)
    else $error("input open while capacity is being computed");

  // A result is never produced over one that is still held.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !(out_valid_r && out_stall))
    else $error("result register overwritten");

  // Sweep and bitmap update never coincide with a new item load.
  a_excl_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.load, cmd.sweep_step, cmd.finish}) <= 1)
    else $error("conflicting datapath commands");

  // A pending clear item enters the check state right after its sweep ends.
  a_clear_report: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP) && sts.sweep_last && item_pend_r |=> state_r == S_CHECK)
    else $error("clear item not reported after sweep");
`endif

endmodule

// ----- verif/wobg_checker.sv -----
// Checker for the write-once block guard: watches the input, result and size
// ports, keeps its own copy of the written-block map, and compares each result.
// Depends on wobg_pkg for the word structs and the kind and status codes.
module wobg_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  wobg_pkg::in_word_t         in_data,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  wobg_pkg::out_word_t        out_data,
  input  logic                       cfg_we,
  input  logic [wobg_pkg::CAP_W-1:0] cfg_data,
  output int                         fail_count,
  output int                         pending_count,
  output int                         checked_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP_W = wobg_pkg::CAP_W;

  logic [wobg_pkg::MAX_BLOCKS_DEF-1:0] shadow_written;
  logic [CAP_W-1:0]                    shadow_total;
  wobg_pkg::out_word_t                 awaited_results[$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
    checked_count = 0;
    shadow_written = '0;
    shadow_total   = wobg_pkg::TOTAL_RESET;
  end

  // Usable blocks: the device size, clamped to the map size, less the map
  // area and one spare block, saturating at zero.
  function automatic logic [CAP_W-1:0] usable_blocks(
    input logic [CAP_W-1:0] total);
    int unsigned clamped;
    int unsigned reserved;
    clamped  = (total > wobg_pkg::MAX_BLOCKS_DEF) ? wobg_pkg::MAX_BLOCKS_DEF : total;
    reserved = clamped / wobg_pkg::MAP_BITS_DEF + 1;
    return (reserved >= clamped) ? '0 : CAP_W'(clamped - reserved);
  endfunction

  // Work out the result of one word and update the shadow map.
  function automatic wobg_pkg::out_word_t guard_outcome(input wobg_pkg::in_word_t w);
    wobg_pkg::out_word_t res;
    res.status   = wobg_pkg::ST_OK;
    res.forward  = 1'b0;
    res.capacity = usable_blocks(shadow_total);
    case (w.kind)
      wobg_pkg::KIND_CLEAR: shadow_written = '0;
      wobg_pkg::KIND_READ, wobg_pkg::KIND_WRITE: begin
        if ({1'b0, w.block} >= res.capacity) begin
          res.status = wobg_pkg::ST_BOUNDS;
        end else if (w.kind == wobg_pkg::KIND_READ) begin
          if (shadow_written[w.block]) res.forward = 1'b1;
          else res.status = wobg_pkg::ST_UNWRITTEN;
        end else if (shadow_written[w.block]) begin
          res.status = wobg_pkg::ST_REWRITE;
        end else begin
          shadow_written[w.block] = 1'b1;
          res.forward = 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic note_mismatch(input string field, input int unsigned want,
                               input int unsigned got);
    fail_count++;
    $error("%s mismatch: expected %0d, actual %0d", field, want, got);
  endtask

  // Results are compared before new words are predicted, so a result can
  // never be matched against a word accepted on the same edge.
  always @(posedge clk) begin
    wobg_pkg::out_word_t want;
    if (!rst_n) begin
      shadow_written = '0;
      shadow_total   = wobg_pkg::TOTAL_RESET;
      awaited_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          fail_count++;
          $error("result word with no word awaited: status %0d forward %0d capacity %0d",
                 out_data.status, out_data.forward, out_data.capacity);
        end else begin
          want = awaited_results.pop_front();
          checked_count++;
          if (out_data.status !== want.status)
            note_mismatch("status", want.status, out_data.status);
          if (out_data.forward !== want.forward)
            note_mismatch("forward", want.forward, out_data.forward);
          if (out_data.capacity !== want.capacity)
            note_mismatch("capacity", want.capacity, out_data.capacity);
        end
      end
      if (cfg_we) shadow_total = cfg_data;
      if (in_valid && !in_stall) awaited_results.push_back(guard_outcome(in_data));
    end
    pending_count = awaited_results.size();
  end

endmodule

// ----- verif/tb_top.sv -----
// Top of the write-once block guard testbench: clock, reset, stimulus, size
// settings, result-side stalls and the verdict. Depends on wobg_pkg, the
// guard RTL and wobg_checker, which does all prediction and comparison.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KIND_W  = wobg_pkg::KIND_W;
  localparam int BLOCK_W = wobg_pkg::BLOCK_W;
  localparam int CAP_W   = wobg_pkg::CAP_W;
  localparam int MAX_BLK = wobg_pkg::MAX_BLOCKS_DEF;

  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 400;
  localparam int POOL_SIZE    = 24;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  wobg_pkg::in_word_t  in_data;
  logic                out_valid;
  logic                out_stall;
  wobg_pkg::out_word_t out_data;
  logic                cfg_we;
  logic [CAP_W-1:0]    cfg_data;

  int fail_count;
  int pending_count;
  int checked_count;
  int cycle_count = 0;
  int sent_count = 0;
  int clear_count = 0;
  int setting_count = 0;
  int burst_left = 0;
  bit hold_done = 1'b0;

  write_once_block_guard dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  wobg_checker guard_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  always #2 clk = ~clk;

  // Run-length guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results awaited",
               CYCLE_LIMIT, pending_count);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Result side: stall in spans of differing character, with one long
  // hold-off while words keep coming so that the guard fills and stalls.
  initial begin : receiver
    int mode;
    int span;
    out_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 150);
      if (!hold_done && sent_count >= HOLD_AFTER) begin
        hold_done = 1'b1;
        @(negedge clk);
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(0, 3) == 0);
          2: out_stall = ($urandom_range(0, 3) != 0);
          default: out_stall = ~out_stall;
        endcase
      end
    end
  end

  // Offer one word; the sender works in bursts with random gaps between them.
  task automatic offer(input logic [KIND_W-1:0] kind, input logic [BLOCK_W-1:0] blk);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid      = 1'b1;
    in_data.kind  = kind;
    in_data.block = blk;
    do @(posedge clk); while (in_stall);
    sent_count++;
    if (kind == wobg_pkg::KIND_CLEAR) clear_count++;
  endtask

  // Stop offering and wait until every awaited result has come back.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  // Size writes happen only with the guard idle.
  task automatic set_total(input logic [CAP_W-1:0] total);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = total;
    @(negedge clk);
    cfg_we = 1'b0;
    setting_count++;
  endtask

  // One random phase at a given size. Most accesses land on a small pool of
  // blocks inside the usable range so that reads find written blocks and
  // rewrites occur; the rest probe the capacity edge or the whole range.
  task automatic run_phase(input logic [CAP_W-1:0] total, input int count);
    logic [BLOCK_W-1:0] pool [POOL_SIZE];
    logic [KIND_W-1:0]  kind;
    logic [BLOCK_W-1:0] blk;
    int lim;
    int lo;
    int hi;
    int pick;
    set_total(total);
    lim = (total > MAX_BLK) ? MAX_BLK : total;
    foreach (pool[i]) pool[i] = (lim > 3) ? BLOCK_W'($urandom_range(0, lim - 3)) : '0;
    repeat (count) begin
      pick = $urandom_range(0, 199);
      if (pick < 2) kind = wobg_pkg::KIND_CLEAR;
      else if (pick < 6) kind = KIND_SPARE;
      else if (pick < 100) kind = wobg_pkg::KIND_WRITE;
      else kind = wobg_pkg::KIND_READ;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        blk = BLOCK_W'($urandom_range(0, 16'hFFFF));
      end else if (pick < 25) begin
        lo  = (lim > 3) ? lim - 3 : 0;
        hi  = (lim > 16'hFFFF) ? 16'hFFFF : lim;
        blk = BLOCK_W'($urandom_range(lo, hi));
      end else begin
        blk = pool[$urandom_range(0, POOL_SIZE - 1)];
      end
      offer(kind, blk);
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    cfg_we   = 1'b0;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: the full-size device after reset.
    offer(wobg_pkg::KIND_READ, 16'd0);
    offer(wobg_pkg::KIND_WRITE, 16'd0);
    offer(wobg_pkg::KIND_WRITE, 16'd0);
    offer(wobg_pkg::KIND_READ, 16'd0);
    offer(wobg_pkg::KIND_WRITE, 16'd65533);
    offer(wobg_pkg::KIND_READ, 16'd65533);
    offer(wobg_pkg::KIND_WRITE, 16'd65534);
    offer(wobg_pkg::KIND_READ, 16'hFFFF);
    offer(KIND_SPARE, 16'hFFFF);
    offer(wobg_pkg::KIND_CLEAR, 16'hAAAA);
    offer(wobg_pkg::KIND_READ, 16'd0);
    offer(wobg_pkg::KIND_READ, 16'd65533);
    offer(wobg_pkg::KIND_WRITE, 16'd0);

    // Directed: zero size, the smallest sizes, the largest register value
    // and the sizes either side of the map-area step.
    set_total('0);
    offer(wobg_pkg::KIND_READ, 16'd5);
    offer(wobg_pkg::KIND_WRITE, 16'd0);
    set_total(17'd1);
    offer(wobg_pkg::KIND_WRITE, 16'd0);
    set_total(17'd2);
    offer(wobg_pkg::KIND_READ, 16'd0);
    offer(wobg_pkg::KIND_WRITE, 16'd1);
    set_total(17'h1FFFF);
    offer(wobg_pkg::KIND_WRITE, 16'd65534);
    offer(wobg_pkg::KIND_WRITE, 16'd65533);
    set_total(17'd65439);
    offer(wobg_pkg::KIND_WRITE, 16'd65437);
    offer(wobg_pkg::KIND_READ, 16'd65438);
    set_total(17'd65440);
    offer(wobg_pkg::KIND_READ, 16'd65437);

    // Random phases across a spread of sizes.
    run_phase(wobg_pkg::TOTAL_RESET, 140);
    run_phase(17'h1FFFF, 135);
    run_phase(17'd65440, 135);
    run_phase(CAP_W'($urandom_range(3, MAX_BLK)), 135);
    run_phase(17'd300, 135);
    run_phase(CAP_W'($urandom_range(MAX_BLK + 1, 17'h1FFFF)), 135);
    run_phase(17'd64, 135);

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Sent %0d words (%0d whole-map clears) over %0d size settings;",
             sent_count, clear_count, setting_count);
    $display("checked %0d results, receiver hold-off %0s.",
             checked_count, hold_done ? "done" : "not reached");
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/wobg_pkg.sv
sv/wobg_dpath.sv
sv/wobg_ctrl.sv
sv/write_once_block_guard.sv
verif/wobg_checker.sv
verif/tb_top.sv
